### src/ilt_pkg.sv
// Package for the indexed list table: word types, request modes and status codes.
`timescale 1ns / 1ps

package ilt_pkg;

  localparam int MODE_W  = 3;
  localparam int POS_W   = 5;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 5;

  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GET    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SET    = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word_in;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] word_out;
    logic [FILL_W-1:0] fill;
  } out_word_t;

endpackage

### src/indexed_list_table_top.sv
// Indexed list table: position-addressed list of words kept in one synchronous memory.
`timescale 1ns / 1ps

// An ordered list of up to CAPACITY words held in a single memory with one write
// and one registered read port. One request word is taken at a time and gives one
// result word. Push, set, an insert at the fill count, the unused modes and requests
// that fail their checks go straight to the result state; pop and get first wait
// for the registered read. An insert below the fill count and any remove move every
// later entry by one place, writing each moved word while the next one is read, so
// they take longer the more entries they move (at most CAPACITY - 1). Every request
// is held in the result state while the previous result still waits in the output
// register.
// The memory needs no clearing after reset: only positions below the fill count
// are read. The result sits in an output register, so a request can be accepted
// while the previous result still waits to be taken.
module indexed_list_table_top #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ilt_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ilt_pkg::out_word_t out_data
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > ilt_pkg::POS_W) ? CW : ilt_pkg::POS_W;
  localparam int SW   = (WORD_BITS < ilt_pkg::WORD_W) ? WORD_BITS : ilt_pkg::WORD_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RDWAIT = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_LAST   = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  logic [SW-1:0] entries_mem [CAPACITY];
  logic [SW-1:0] rd_data_r;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              fill_r, fill_nxt;
  logic [CW-1:0]              moves_r, moves_nxt;
  logic [AW-1:0]              src_r, src_nxt;
  logic [AW-1:0]              pos_r, pos_nxt;
  logic                       up_r, up_nxt;
  logic [ilt_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [SW-1:0]              word_r, word_nxt;
  logic                       out_valid_r, out_valid_nxt;
  ilt_pkg::out_word_t         out_data_r, out_data_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  logic [CMPW-1:0] pos_c;
  logic [CMPW-1:0] fill_c;
  logic [SW-1:0]   win;
  logic            full;

  assign pos_c  = CMPW'(in_data.position);
  assign fill_c = CMPW'(fill_r);
  assign win    = SW'(in_data.word_in);
  assign full   = (fill_r == CW'(CAPACITY));

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    moves_nxt     = moves_r;
    src_nxt       = src_r;
    pos_nxt       = pos_r;
    up_nxt        = up_r;
    status_nxt    = status_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = src_r;
    wr_data       = word_r;
    rd_en         = 1'b0;
    rd_addr       = src_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ilt_pkg::ST_OK;
          word_nxt   = '0;
          pos_nxt    = AW'(in_data.position);
          state_nxt  = S_RESP;
          case (in_data.mode)
            ilt_pkg::MODE_PUSH: begin
              if (full) begin
                status_nxt = ilt_pkg::ST_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = AW'(fill_r);
                wr_data  = win;
                fill_nxt = fill_r + 1'b1;
              end
            end
            ilt_pkg::MODE_POP: begin
              if (fill_r == '0) begin
                status_nxt = ilt_pkg::ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(fill_r - 1'b1);
                fill_nxt  = fill_r - 1'b1;
                moves_nxt = '0;
                state_nxt = S_RDWAIT;
              end
            end
            ilt_pkg::MODE_INSERT: begin
              if (pos_c > fill_c) begin
                status_nxt = ilt_pkg::ST_BAD_INDEX;
              end else if (full) begin
                status_nxt = ilt_pkg::ST_FULL;
              end else if (pos_c == fill_c) begin
                wr_en    = 1'b1;
                wr_addr  = AW'(in_data.position);
                wr_data  = win;
                fill_nxt = fill_r + 1'b1;
              end else begin
                // Entries move up starting from the top; the new word goes in last.
                rd_en     = 1'b1;
                rd_addr   = AW'(fill_r - 1'b1);
                src_nxt   = AW'(fill_r - 1'b1);
                moves_nxt = CW'(fill_c - pos_c);
                up_nxt    = 1'b1;
                word_nxt  = win;
                fill_nxt  = fill_r + 1'b1;
                state_nxt = S_SHIFT;
              end
            end
            ilt_pkg::MODE_REMOVE: begin
              if (pos_c >= fill_c) begin
                status_nxt = ilt_pkg::ST_BAD_INDEX;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_data.position);
                src_nxt   = AW'(in_data.position);
                moves_nxt = CW'(fill_c - pos_c - 1'b1);
                up_nxt    = 1'b0;
                fill_nxt  = fill_r - 1'b1;
                state_nxt = S_RDWAIT;
              end
            end
            ilt_pkg::MODE_GET: begin
              if (pos_c >= fill_c) begin
                status_nxt = ilt_pkg::ST_BAD_INDEX;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_data.position);
                moves_nxt = '0;
                state_nxt = S_RDWAIT;
              end
            end
            ilt_pkg::MODE_SET: begin
              if (pos_c >= fill_c) begin
                status_nxt = ilt_pkg::ST_BAD_INDEX;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AW'(in_data.position);
                wr_data = win;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RDWAIT: begin
        word_nxt = rd_data_r;
        if (moves_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = src_r + 1'b1;
          src_nxt   = src_r + 1'b1;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // The word read last cycle from src_r lands one place up or down, while
        // the next source is read ahead.
        wr_en     = 1'b1;
        wr_addr   = up_r ? (src_r + 1'b1) : (src_r - 1'b1);
        wr_data   = rd_data_r;
        moves_nxt = moves_r - 1'b1;
        if (moves_r > CW'(1)) begin
          rd_en   = 1'b1;
          rd_addr = up_r ? (src_r - 1'b1) : (src_r + 1'b1);
          src_nxt = up_r ? (src_r - 1'b1) : (src_r + 1'b1);
        end else begin
          state_nxt = up_r ? S_LAST : S_RESP;
        end
      end
      S_LAST: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = word_r;
        word_nxt  = '0;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.status   = status_r;
          out_data_nxt.word_out = ilt_pkg::WORD_W'(word_r);
          out_data_nxt.fill     = ilt_pkg::FILL_W'(fill_r);
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= entries_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    moves_r    <= moves_nxt;
    src_r      <= src_nxt;
    pos_r      <= pos_nxt;
    up_r       <= up_nxt;
    status_r   <= status_nxt;
    word_r     <= word_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
